// ===== rtl/core/dess_pkg.sv =====
// Package: sizes, codes, hash functions and control types of the edge set store.
package dess_pkg;

    localparam int EDGE_SLOTS = 1024;
    localparam int HASH_SLOTS = 2048;
    localparam int ADJ_SLOTS  = 2048;
    localparam int EW = $clog2(EDGE_SLOTS);
    localparam int HW = $clog2(HASH_SLOTS);
    localparam int AW = $clog2(ADJ_SLOTS);
    localparam int CW = EW + 1;
    localparam int QDEPTH = 2;
    localparam int HA_MAX = (HASH_SLOTS > ADJ_SLOTS) ? HASH_SLOTS : ADJ_SLOTS;
    localparam int CLR_SLOTS = (HA_MAX > EDGE_SLOTS) ? HA_MAX : EDGE_SLOTS;
    localparam int CLRW = $clog2(CLR_SLOTS);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_COUNT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOEFF  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] src;
        logic [31:0] dst;
        logic [HW-1:0] ehome;
        logic [AW-1:0] ahome;
    } t_item;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_if;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_FE_RD, S_FE_EW, S_FE_CMP, S_FA_RD, S_FA_CMP, S_DISPATCH,
        S_ADD_FREE, S_ADD_LINK, S_ADD_ADJ, S_PL_RD, S_PL_CHK,
        S_UN_CLR, S_UN_RD, S_UN_CHK, S_UN_HASH, S_RP_RD, S_RP_CHK,
        S_DL_RD, S_DL_LINK, S_DL_FA_RD, S_DL_FA_CMP, S_CNT_RD, S_CNT_STEP,
        S_RESP
    } t_state;

    function automatic logic [31:0] mix64(input logic [63:0] k_in);
        logic [63:0] k;
        k = (~k_in) + (k_in << 18);
        k = k ^ (k >> 31);
        k = (k + (k << 2)) + (k << 4);
        k = k ^ (k >> 11);
        k = k + (k << 6);
        k = k ^ (k >> 22);
        return k[31:0];
    endfunction

    function automatic logic [31:0] mix32(input logic [31:0] k_in);
        logic [31:0] k;
        k = ~k_in + (k_in << 15);
        k = k ^ (k >> 12);
        k = k + (k << 2);
        k = k ^ (k >> 4);
        k = (k + (k << 3)) + (k << 11);
        k = k ^ (k >> 16);
        return k;
    endfunction

endpackage

// ===== rtl/core/dess_front.sv =====
// Front end: accepts commands, hashes keys into a registered item, queues items.
module dess_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_cmd,
    input  logic [31:0]   i_src_vertex,
    input  logic [31:0]   i_dst_vertex,
    output logic          o_busy,
    output dess_pkg::t_item o_item,
    output dess_pkg::t_q_if o_q,
    input  logic          i_pop
);
    import dess_pkg::*;

    logic          r_hv;
    t_item         r_hit;
    t_item         r_q [QDEPTH];
    logic [0:0]    r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;
    logic [31:0]   eh, ah;

    assign o_busy = r_hv;
    assign eh = mix64({i_src_vertex, i_dst_vertex});
    assign ah = mix32(i_src_vertex);
    assign push = r_hv && (r_cnt != 2'(QDEPTH));
    assign pop  = i_pop && (r_cnt != 2'd0);
    assign o_item = r_q[r_rp];
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.ready = (r_cnt != 2'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_start && !r_hv) begin
                r_hv <= 1'b1;
                r_hit.cmd   <= t_cmd'(i_cmd);
                r_hit.src   <= i_src_vertex;
                r_hit.dst   <= i_dst_vertex;
                r_hit.ehome <= eh[HW-1:0];
                r_hit.ahome <= ah[AW-1:0];
            end else if (push) begin
                r_hv <= 1'b0;
            end
            if (push) begin
                r_q[r_wp] <= r_hit;
                r_wp <= r_wp + 1'b1;
            end
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hv && !push) |=> r_hv) else $error("held item lost");
    cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue overflow");
    no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1)) else $error("queue underflow");
endmodule

// ===== rtl/core/dess_back.sv =====
// Back end: executes queued commands over the hash, edge and adjacency memories.
module dess_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dess_pkg::t_item i_item,
    input  dess_pkg::t_q_if i_q,
    output logic          o_pop,
    output logic          o_valid,
    output logic          o_link_present,
    output logic [10:0]   o_neighbor_count,
    output logic [1:0]    o_status
);
    import dess_pkg::*;

    // memories; hash and adjacency words carry their valid flag in the top bit
    logic [EW:0]   m_hash [HASH_SLOTS];
    logic [31:0]   m_esrc [EDGE_SLOTS];
    logic [31:0]   m_edst [EDGE_SLOTS];
    logic [EW:0]   m_next [EDGE_SLOTS];
    logic [EW:0]   m_prev [EDGE_SLOTS];
    logic [EW-1:0] m_free [EDGE_SLOTS];
    logic [32:0]   m_avtx [ADJ_SLOTS];
    logic [EW:0]   m_ahead[ADJ_SLOTS];

    // memory read data
    logic [EW-1:0] r_hrd;
    logic          r_hvrd;
    logic [31:0]   r_srd, r_drd;
    logic [EW:0]   r_nrd, r_prd;
    logic [EW-1:0] r_frd;
    logic [31:0]   r_avrd;
    logic          r_avvrd;
    logic [EW:0]   r_ahrd;

    t_state  r_st, n_st;
    t_item   r_it;
    logic [HW-1:0] r_hi, n_hi, r_hhole, n_hhole;
    logic [AW-1:0] r_ai, n_ai, r_afound, n_afound;
    logic          r_ahit, n_ahit;
    logic [HW:0]   r_n, n_n;
    logic [EW-1:0] r_e, n_e, r_mv, n_mv, r_de, n_de;
    logic [CW-1:0] r_live, n_live;
    logic [AW:0]   r_aused, n_aused;
    logic [EW:0]   r_k, n_k, r_nx, n_nx, r_pv, n_pv;
    logic [10:0]   r_cnt, n_cnt;
    logic          r_pres, n_pres;
    t_status       r_stat, n_stat;
    logic [31:0]   r_ks, n_ks, r_kd, n_kd;
    logic [31:0]   kh;
    logic          r_ov, n_ov;
    logic [CLRW-1:0] r_clr, n_clr;

    // memory ports, driven by the sequencer
    logic          hre, hwe, hwv;
    logic [HW-1:0] ha;
    logic [EW-1:0] hwd;
    logic          ere, ewe;
    logic [EW-1:0] ea;
    logic          nwe, pwe;
    logic [EW-1:0] na, pa;
    logic [EW:0]   nwd, pwd;
    logic          pre;
    logic          fre, fwe;
    logic [EW-1:0] fa, fwd;
    logic          are, awe, awv, ahwe;
    logic [AW-1:0] aa;
    logic [EW:0]   ahwd;

    localparam logic [EW:0] NIL = {1'b1, {EW{1'b0}}};

    assign kh = mix64({r_ks, r_kd});

    always_ff @(posedge i_clk) begin
        if (hre) begin
            r_hrd  <= m_hash[ha][EW-1:0];
            r_hvrd <= m_hash[ha][EW];
        end
        if (hwe) m_hash[ha] <= {hwv, hwd};
        if (ere) begin
            r_srd <= m_esrc[ea];
            r_drd <= m_edst[ea];
            r_nrd <= m_next[ea];
        end
        if (ewe) begin
            m_esrc[ea] <= r_it.src;
            m_edst[ea] <= r_it.dst;
        end
        if (pre) r_prd <= m_prev[pa];
        if (nwe) m_next[na] <= nwd;
        if (pwe) m_prev[pa] <= pwd;
        if (fre) r_frd <= m_free[fa];
        if (fwe) m_free[fa] <= fwd;
        if (are) begin
            r_avrd  <= m_avtx[aa][31:0];
            r_avvrd <= m_avtx[aa][32];
            r_ahrd  <= m_ahead[aa];
        end
        if (awe) m_avtx[aa] <= {awv, r_it.src};
        if (ahwe) m_ahead[aa] <= ahwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_INIT;
            r_clr  <= '0;
            r_live <= '0;
            r_aused <= '0;
        end else begin
            r_st <= n_st;
            r_clr <= n_clr;
            r_live <= n_live;
            r_aused <= n_aused;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_it <= i_item;
        r_hi <= n_hi; r_hhole <= n_hhole; r_ai <= n_ai; r_afound <= n_afound;
        r_ahit <= n_ahit; r_n <= n_n; r_e <= n_e; r_mv <= n_mv; r_k <= n_k;
        r_nx <= n_nx; r_pv <= n_pv; r_cnt <= n_cnt; r_pres <= n_pres;
        r_stat <= n_stat; r_ks <= n_ks; r_kd <= n_kd; r_ov <= n_ov; r_de <= n_de;
    end

    assign o_valid = (r_st == S_RESP);
    assign o_link_present = r_pres;
    assign o_neighbor_count = r_cnt;
    assign o_status = r_stat;

    always_comb begin
        n_st = r_st; n_hi = r_hi; n_hhole = r_hhole; n_ai = r_ai;
        n_afound = r_afound; n_ahit = r_ahit; n_n = r_n; n_e = r_e; n_mv = r_mv;
        n_live = r_live; n_aused = r_aused; n_k = r_k; n_nx = r_nx; n_pv = r_pv;
        n_cnt = r_cnt; n_pres = r_pres; n_stat = r_stat; n_ks = r_ks; n_kd = r_kd;
        n_ov = r_ov; n_de = r_de; n_clr = r_clr;
        o_pop = 1'b0;
        hre = 1'b0; hwe = 1'b0; hwv = 1'b0; ha = r_hi; hwd = r_e;
        ere = 1'b0; ewe = 1'b0; ea = r_hrd;
        nwe = 1'b0; pwe = 1'b0; na = r_e; pa = r_e; nwd = NIL; pwd = NIL; pre = 1'b0;
        fre = 1'b0; fwe = 1'b0; fa = r_live[EW-1:0]; fwd = r_e;
        are = 1'b0; awe = 1'b0; awv = 1'b0; ahwe = 1'b0; aa = r_ai; ahwd = NIL;
        unique case (r_st)
            // clearing pass: empty hash and adjacency slots, free list entry i = i
            S_INIT: begin
                ha = r_clr[HW-1:0]; hwv = 1'b0;
                hwe = ({1'b0, r_clr} < (CLRW+1)'(HASH_SLOTS));
                aa = r_clr[AW-1:0]; awv = 1'b0;
                awe = ({1'b0, r_clr} < (CLRW+1)'(ADJ_SLOTS));
                fa = r_clr[EW-1:0]; fwd = r_clr[EW-1:0];
                fwe = ({1'b0, r_clr} < (CLRW+1)'(EDGE_SLOTS));
                n_clr = r_clr + 1'b1;
                if (r_clr == CLRW'(CLR_SLOTS - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    n_hi = i_item.ehome;
                    n_ai = i_item.ahome;
                    n_n = '0;
                    n_pres = 1'b0; n_cnt = '0; n_stat = ST_DONE;
                    n_st = (i_item.cmd == CMD_COUNT) ? S_FA_RD : S_FE_RD;
                end
            end
            // find edge: probe hash, then compare stored edge
            S_FE_RD: begin
                hre = 1'b1;
                n_st = S_FE_EW;
            end
            S_FE_EW: begin
                if (!r_hvrd || r_n == (HW+1)'(HASH_SLOTS)) begin
                    n_ahit = 1'b0;
                    n_st = S_DISPATCH;
                end else begin
                    ere = 1'b1; ea = r_hrd;
                    n_e = r_hrd;
                    n_st = S_FE_CMP;
                end
            end
            S_FE_CMP: begin
                if (r_srd == r_it.src && r_drd == r_it.dst) begin
                    n_ahit = 1'b1;
                    n_nx = r_nrd;
                    n_hhole = r_hi;
                    n_st = S_DISPATCH;
                end else begin
                    n_hi = r_hi + 1'b1;
                    n_n = r_n + 1'b1;
                    n_st = S_FE_RD;
                end
            end
            S_DISPATCH: begin
                // r_ahit here means edge found
                n_n = '0;
                priority case (r_it.cmd)
                    CMD_CHECK: begin
                        n_pres = r_ahit;
                        n_st = S_RESP;
                    end
                    CMD_DEL: begin
                        if (!r_ahit) begin
                            n_stat = ST_NOEFF; n_st = S_RESP;
                        end else begin
                            pre = 1'b1; pa = r_e;
                            n_st = S_UN_CLR;
                        end
                    end
                    default: begin
                        if (r_ahit) begin
                            n_stat = ST_NOEFF; n_st = S_RESP;
                        end else begin
                            n_st = S_FA_RD;
                        end
                    end
                endcase
            end
            // find adjacency entry
            S_FA_RD: begin
                are = 1'b1;
                n_st = S_FA_CMP;
            end
            S_FA_CMP: begin
                if (!r_avvrd || r_n == (HW+1)'(ADJ_SLOTS) || r_avrd == r_it.src) begin
                    n_ahit = r_avvrd && r_avrd == r_it.src && r_n != (HW+1)'(ADJ_SLOTS);
                    n_afound = r_ai;
                    n_k = r_ahrd;
                    if (r_it.cmd == CMD_COUNT) begin
                        n_n = '0;
                        n_st = (r_avvrd && r_avrd == r_it.src && r_n != (HW+1)'(ADJ_SLOTS))
                               ? S_CNT_RD : S_RESP;
                    end else if (r_live >= CW'(EDGE_SLOTS) ||
                                 32'(r_live) >= 32'(HASH_SLOTS) ||
                                 (!(r_avvrd && r_avrd == r_it.src &&
                                    r_n != (HW+1)'(ADJ_SLOTS)) &&
                                  r_aused >= (AW+1)'(ADJ_SLOTS))) begin
                        n_stat = ST_FULL; n_st = S_RESP;
                    end else begin
                        fre = 1'b1; fa = r_live[EW-1:0];
                        n_st = S_ADD_FREE;
                    end
                end else begin
                    n_ai = r_ai + 1'b1;
                    n_n = r_n + 1'b1;
                    n_st = S_FA_RD;
                end
            end
            S_ADD_FREE: begin
                n_e = r_frd;
                n_live = r_live + 1'b1;
                n_st = S_ADD_LINK;
            end
            S_ADD_LINK: begin
                ewe = 1'b1; ea = r_e;
                nwe = 1'b1; na = r_e;
                pwe = 1'b1; pa = r_e; pwd = NIL;
                nwd = r_ahit ? r_k : NIL;
                n_st = S_ADD_ADJ;
            end
            S_ADD_ADJ: begin
                aa = r_afound;
                ahwe = 1'b1; ahwd = {1'b0, r_e};
                if (!r_ahit) begin
                    awe = 1'b1; awv = 1'b1;
                    n_aused = r_aused + 1'b1;
                end else if (!r_k[EW]) begin
                    pwe = 1'b1; pa = r_k[EW-1:0]; pwd = {1'b0, r_e};
                end
                n_ks = r_it.src; n_kd = r_it.dst; n_ov = 1'b0;
                n_st = S_PL_RD;
                n_hi = r_it.ehome; n_n = '0;
            end
            // place edge r_e at first free probe from r_hi
            S_PL_RD: begin
                hre = 1'b1;
                n_st = S_PL_CHK;
            end
            S_PL_CHK: begin
                if (!r_hvrd) begin
                    hwe = 1'b1; hwv = 1'b1; hwd = r_e;
                    n_st = r_ov ? S_RP_RD : S_RESP;
                    n_hi = r_hhole + 1'b1;
                end else if (r_n == (HW+1)'(HASH_SLOTS - 1)) begin
                    n_st = r_ov ? S_RP_RD : S_RESP;
                    n_hi = r_hhole + 1'b1;
                end else begin
                    n_hi = r_hi + 1'b1; n_n = r_n + 1'b1;
                    n_st = S_PL_RD;
                end
                if (r_ov && n_st == S_RP_RD) n_n = r_mv[0] ? r_n : r_n;
            end
            // delete: clear found hash slot, then reinsert rest of cluster
            S_UN_CLR: begin
                n_pv = r_prd;
                n_de = r_e;
                ha = r_hhole; hwe = 1'b1; hwv = 1'b0;
                n_hi = r_hhole + 1'b1;
                n_hhole = r_hhole + 1'b1;
                n_n = '0;
                n_ov = 1'b1;
                n_st = S_RP_RD;
            end
            S_RP_RD: begin
                ha = r_hhole; hre = 1'b1;
                n_st = S_RP_CHK;
            end
            S_RP_CHK: begin
                if (!r_hvrd || r_n == (HW+1)'(HASH_SLOTS)) begin
                    n_st = S_DL_RD;
                end else begin
                    ha = r_hhole; hwe = 1'b1; hwv = 1'b0;
                    n_mv = r_hrd;
                    ere = 1'b1; ea = r_hrd;
                    n_st = S_UN_HASH;
                end
            end
            S_UN_HASH: begin
                n_ks = r_srd; n_kd = r_drd;
                n_st = S_UN_RD;
            end
            S_UN_RD: begin
                n_hi = kh[HW-1:0];
                n_e = r_mv;
                n_n = '0;
                n_st = S_UN_CHK;
            end
            S_UN_CHK: begin
                // advance cluster cursor, then place moved entry
                n_hhole = r_hhole + 1'b1;
                n_st = S_PL_RD;
            end
            S_DL_RD: begin
                // unlink the deleted edge using its saved next / prev
                if (!r_nx[EW]) begin
                    pwe = 1'b1; pa = r_nx[EW-1:0]; pwd = r_pv;
                end
                if (!r_pv[EW]) begin
                    nwe = 1'b1; na = r_pv[EW-1:0]; nwd = r_nx;
                    n_st = S_DL_LINK;
                end else begin
                    n_ai = r_it.ahome; n_n = '0;
                    n_st = S_DL_FA_RD;
                end
            end
            S_DL_FA_RD: begin
                are = 1'b1;
                n_st = S_DL_FA_CMP;
            end
            S_DL_FA_CMP: begin
                if (!r_avvrd || r_n == (HW+1)'(ADJ_SLOTS)) begin
                    n_st = S_DL_LINK;
                end else if (r_avrd == r_it.src) begin
                    ahwe = 1'b1; ahwd = r_nx;
                    n_st = S_DL_LINK;
                end else begin
                    n_ai = r_ai + 1'b1; n_n = r_n + 1'b1;
                    n_st = S_DL_FA_RD;
                end
            end
            S_DL_LINK: begin
                if (r_live != '0) begin
                    n_live = r_live - 1'b1;
                    fwe = 1'b1; fa = n_live[EW-1:0]; fwd = r_de;
                end
                n_st = S_RESP;
            end
            // neighbor count walk
            S_CNT_RD: begin
                if (r_k[EW] || r_n == (HW+1)'(EDGE_SLOTS)) begin
                    n_st = S_RESP;
                end else begin
                    ere = 1'b1; ea = r_k[EW-1:0];
                    n_st = S_CNT_STEP;
                end
            end
            S_CNT_STEP: begin
                n_cnt = (r_cnt == 11'h7ff) ? r_cnt : r_cnt + 1'b1;
                n_k = r_nrd; n_n = r_n + 1'b1;
                n_st = S_CNT_RD;
            end
            S_RESP: begin
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(EDGE_SLOTS)) else $error("live count overflow");
    one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_st == S_IDLE && i_q.valid)) else $error("pop outside idle");
    resp_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
    full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> r_it.cmd == CMD_ADD)
        else $error("full status on non-add");
endmodule

// ===== rtl/core/dynamic_edge_set_store.sv =====
// Top level of the dynamic edge set store: front end, item queue and back end.
// One command per item; start is taken when busy is low, and the result appears
// for one cycle under o_valid, which cannot be stalled. After reset a clearing
// pass empties the hash and adjacency tables and fills the free list; items
// taken meanwhile wait. A check of an edge whose home slot is empty reads the
// hash slot, dispatches and then strobes its result. Each hash probe step reads
// the hash slot and then the stored edge; adjacency probes and the edges of a
// count walk each take a read state and a check state. A delete re-places each
// later entry of its probe cluster. The front holds one item and a two-entry
// queue, so up to three items can be taken while the back end works.
module dynamic_edge_set_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_src_vertex,
    input  logic [31:0] i_dst_vertex,
    output logic        o_valid,
    output logic        o_link_present,
    output logic [10:0] o_neighbor_count,
    output logic [1:0]  o_status
);
    import dess_pkg::*;

    t_item item;
    t_q_if q;
    logic  pop;

    dess_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_cmd(i_cmd),
        .i_src_vertex(i_src_vertex), .i_dst_vertex(i_dst_vertex),
        .o_busy(busy), .o_item(item), .o_q(q), .i_pop(pop)
    );

    dess_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_q(q), .o_pop(pop),
        .o_valid(o_valid), .o_link_present(o_link_present),
        .o_neighbor_count(o_neighbor_count), .o_status(o_status)
    );
endmodule
